// ===== sv/efrt_pkg.sv =====
// Shared constants, codes and control structs for the explicit frame remap table.
// No dependencies; every other file imports this package.
`default_nettype none

package efrt_pkg;

    localparam int EFRT_TABLE_DEPTH   = 1024;
    localparam int EFRT_INVERSE_DEPTH = 4096;
    localparam int EFRT_FRAME_BITS    = 24;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_mode MODE_LOAD = 2'd0;
    localparam t_mode MODE_FWD  = 2'd1;
    localparam t_mode MODE_INV  = 2'd2;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_SPAN  = 2'd2;
    localparam t_status STAT_FULL  = 2'd3;

    // result source for a deferred beat
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_PEND = 2'd0;
    localparam t_sel SEL_TAB  = 2'd1;
    localparam t_sel SEL_INV  = 2'd2;

    // walk counter operations
    typedef logic [2:0] t_walk;
    localparam t_walk WALK_HOLD = 3'd0;
    localparam t_walk WALK_ZERO = 3'd1;
    localparam t_walk WALK_TOP  = 3'd2;
    localparam t_walk WALK_INC  = 3'd3;
    localparam t_walk WALK_DEC  = 3'd4;

    typedef struct packed {
        logic  accept;
        logic  exec;
        logic  clr_en;
        logic  scat_rd;
        logic  fill_rd;
        logic  fill_init;
        t_walk walk_op;
    } t_cmd;

    typedef struct packed {
        logic item_imm;
        logic pend_build;
        logic walk_span_end;
        logic walk_zero;
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/efrt_intf.sv =====
// Handshake interfaces for the item, result and configuration channels.
// Depends on efrt_pkg.
`default_nettype none

interface efrt_in_if
    import efrt_pkg::*;
#(
    parameter int FRAME_BITS = EFRT_FRAME_BITS
);
    logic                         valid;
    logic                         ready;
    t_mode                        mode;
    logic signed [FRAME_BITS-1:0] frame;
    logic                         last;

    modport source (output valid, output mode, output frame, output last, input ready);
    modport sink   (input valid, input mode, input frame, input last, output ready);
endinterface

interface efrt_out_if
    import efrt_pkg::*;
#(
    parameter int FRAME_BITS = EFRT_FRAME_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [FRAME_BITS-1:0] mapped_frame;
    t_status                      status;

    modport source (output valid, output mapped_frame, output status, input ready);
    modport sink   (input valid, input mapped_frame, input status, output ready);
endinterface

interface efrt_cfg_if
    import efrt_pkg::*;
#(
    parameter int FRAME_BITS = EFRT_FRAME_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [FRAME_BITS-1:0] first_output_frame;

    modport source (output valid, output first_output_frame, input ready);
    modport sink   (input valid, input first_output_frame, output ready);
endinterface

`default_nettype wire

// ===== sv/explicit_frame_remap_table.sv =====
// Explicit frame remap table, top level: controller, datapath and result queue.
// A plain load or an unused mode is answered on acceptance; a query is answered from the EXEC
// state after a registered store read. A load with last then runs the clear, scatter and
// fill walks over the inverse store (span capped at INVERSE_DEPTH); no item is taken meanwhile.
// Synchronous active-low reset clears control state; the stores hold no reset value and
// need no sweep after reset, since each build clears its own span first.
`default_nettype none

module explicit_frame_remap_table
    import efrt_pkg::*;
#(
    parameter int TABLE_DEPTH   = EFRT_TABLE_DEPTH,
    parameter int INVERSE_DEPTH = EFRT_INVERSE_DEPTH,
    parameter int FRAME_BITS    = EFRT_FRAME_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    efrt_in_if.sink    i_in,
    efrt_out_if.source o_out,
    efrt_cfg_if.sink   i_cfg
);

    t_cmd                         cmd;
    t_sts                         sts;
    logic                         in_ready;
    logic                         q_full;
    logic                         push;
    logic signed [FRAME_BITS-1:0] push_mapped;
    t_status                      push_status;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    efrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_q_full   (q_full),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    efrt_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .INVERSE_DEPTH (INVERSE_DEPTH),
        .FRAME_BITS    (FRAME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mode      (i_in.mode),
        .i_frame     (i_in.frame),
        .i_last      (i_in.last),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.first_output_frame),
        .o_push      (push),
        .o_mapped    (push_mapped),
        .o_status    (push_status)
    );

    efrt_outq #(
        .FRAME_BITS (FRAME_BITS)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_mapped (push_mapped),
        .i_status (push_status),
        .o_full   (q_full),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_mapped (o_out.mapped_frame),
        .o_status (o_out.status)
    );

endmodule

`default_nettype wire

// ===== sv/efrt_outq.sv =====
// Two-entry result queue between the datapath and the output channel.
// Depends on efrt_pkg.
`default_nettype none

module efrt_outq
    import efrt_pkg::*;
#(
    parameter int FRAME_BITS = EFRT_FRAME_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic signed [FRAME_BITS-1:0] i_mapped,
    input  wire t_status                      i_status,
    output logic                              o_full,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [FRAME_BITS-1:0]      o_mapped,
    output t_status                           o_status
);

    logic signed [FRAME_BITS-1:0] r_mf [2];
    t_status                      r_st [2];
    logic                         r_wp;
    logic                         r_rp;
    logic [1:0]                   r_cnt;
    logic                         pop;

    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_cnt != 2'd0);
    assign o_full   = (r_cnt == 2'd2);
    assign o_mapped = r_mf[r_rp];
    assign o_status = r_st[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mf[r_wp] <= i_mapped;
            r_st[r_wp] <= i_status;
        end
    end

endmodule

`default_nettype wire

// ===== sv/efrt_dp.sv =====
// Datapath: frame table, inverse store with defined flags, run tracking,
// query indexing, build walk counter and config register. Depends on efrt_pkg.
`default_nettype none

module efrt_dp
    import efrt_pkg::*;
#(
    parameter int TABLE_DEPTH   = EFRT_TABLE_DEPTH,
    parameter int INVERSE_DEPTH = EFRT_INVERSE_DEPTH,
    parameter int FRAME_BITS    = EFRT_FRAME_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cmd                         i_cmd,
    output t_sts                              o_sts,
    input  wire t_mode                        i_mode,
    input  wire logic signed [FRAME_BITS-1:0] i_frame,
    input  wire logic                         i_last,
    input  wire logic                         i_cfg_valid,
    input  wire logic signed [FRAME_BITS-1:0] i_cfg_data,
    output logic                              o_push,
    output logic signed [FRAME_BITS-1:0]      o_mapped,
    output t_status                           o_status
);

    localparam int TW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(INVERSE_DEPTH);
    localparam int SW = $clog2(INVERSE_DEPTH + 1);
    localparam int DW = FRAME_BITS + 1;
    localparam int WW = (CW > SW) ? CW : SW;
    localparam int XW = ((DW > WW) ? DW : WW) + 1;

    // run state
    logic [CW-1:0]                r_count;
    logic signed [FRAME_BITS-1:0] r_low;
    logic signed [FRAME_BITS-1:0] r_high;
    logic                         r_open;
    logic                         r_wide;
    logic [SW-1:0]                r_span;
    logic signed [FRAME_BITS-1:0] r_first;
    logic signed [FRAME_BITS-1:0] r_bfirst;

    // deferred beat
    logic signed [FRAME_BITS-1:0] r_pend_frame;
    t_status                      r_pend_status;
    t_sel                         r_pend_sel;
    logic                         r_pend_build;
    logic signed [FRAME_BITS-1:0] n_pend_frame;
    t_status                      n_pend_status;
    t_sel                         n_pend_sel;

    // stores
    logic signed [FRAME_BITS-1:0] r_tab_mem [TABLE_DEPTH];
    logic signed [FRAME_BITS-1:0] r_tab_q;
    logic signed [FRAME_BITS-1:0] r_inv_mem [INVERSE_DEPTH];
    logic signed [FRAME_BITS-1:0] r_inv_q;
    logic                         r_def_mem [INVERSE_DEPTH];
    logic                         r_def_q;

    // build walk
    logic [WW-1:0]                r_walk;
    logic [WW-1:0]                n_walk;
    logic                         r_scat_v;
    logic [TW-1:0]                r_scat_i;
    logic                         r_fill_v;
    logic [IW-1:0]                r_fill_a;
    logic signed [FRAME_BITS-1:0] r_cur;
    logic signed [FRAME_BITS-1:0] cur_next;

    // load path
    logic                         acc_load;
    logic [CW-1:0]                base_count;
    logic signed [FRAME_BITS-1:0] base_low;
    logic signed [FRAME_BITS-1:0] base_high;
    logic                         store;
    logic                         inv_empty;

    // span at build start
    logic signed [DW-1:0]         sp_diff;
    logic signed [XW-1:0]         x_sp_diff;
    logic signed [XW-1:0]         x_inv_lim;
    logic                         span_wide;
    logic [SW-1:0]                span_val;

    // query indexing
    logic signed [DW-1:0]         f_diff;
    logic signed [XW-1:0]         x_f_diff;
    logic signed [XW-1:0]         x_count;
    logic [TW-1:0]                fwd_idx;
    logic signed [DW-1:0]         i_diff;
    logic signed [XW-1:0]         x_i_diff;
    logic signed [XW-1:0]         x_span;
    logic [IW-1:0]                inv_idx;

    // scatter
    logic signed [DW-1:0]         s_diff;
    logic signed [XW-1:0]         x_s_diff;
    logic                         scat_hit;
    logic [IW-1:0]                s_idx;
    logic signed [FRAME_BITS-1:0] s_val;

    // store ports
    logic [TW-1:0]                tab_raddr;
    logic [IW-1:0]                inv_raddr;
    logic                         inv_we;
    logic [IW-1:0]                inv_wa;
    logic signed [FRAME_BITS-1:0] inv_wd;
    logic                         def_we;
    logic [IW-1:0]                def_wa;
    logic                         def_wd;

    assign acc_load   = i_cmd.accept && (i_mode == MODE_LOAD);
    assign base_count = r_open ? r_count : '0;
    assign base_low   = r_open ? r_low : i_frame;
    assign base_high  = r_open ? r_high : i_frame;
    assign store      = (base_count < CW'(TABLE_DEPTH));
    assign inv_empty  = r_open || (r_count == '0);

    assign sp_diff   = DW'(r_high) - DW'(r_low);
    assign x_sp_diff = XW'(sp_diff);
    assign x_inv_lim = XW'(INVERSE_DEPTH);
    assign span_wide = (x_sp_diff >= x_inv_lim);
    assign span_val  = span_wide ? SW'(INVERSE_DEPTH) : SW'(sp_diff + DW'(1));

    assign f_diff   = DW'(i_frame) - DW'(r_first);
    assign x_f_diff = XW'(f_diff);
    assign x_count  = XW'(r_count);
    assign i_diff   = DW'(i_frame) - DW'(r_low);
    assign x_i_diff = XW'(i_diff);
    assign x_span   = XW'(r_span);

    always_comb begin
        if (f_diff < 0) begin
            fwd_idx = '0;
        end else if (x_f_diff >= x_count) begin
            fwd_idx = TW'(r_count - CW'(1));
        end else begin
            fwd_idx = TW'(f_diff);
        end
        if (i_diff < 0) begin
            inv_idx = '0;
        end else if (x_i_diff >= x_span) begin
            inv_idx = IW'(r_span - SW'(1));
        end else begin
            inv_idx = IW'(i_diff);
        end
    end

    assign s_diff   = DW'(r_tab_q) - DW'(r_low);
    assign x_s_diff = XW'(s_diff);
    assign scat_hit = r_scat_v && !s_diff[DW-1] && (x_s_diff < x_span);
    assign s_idx    = IW'(s_diff);
    assign s_val    = r_bfirst + FRAME_BITS'(r_scat_i);
    assign cur_next = r_def_q ? r_inv_q : r_cur;

    assign tab_raddr = i_cmd.scat_rd ? r_walk[TW-1:0] : fwd_idx;
    assign inv_raddr = i_cmd.fill_rd ? r_walk[IW-1:0] : inv_idx;

    always_comb begin
        inv_we = 1'b0;
        inv_wa = s_idx;
        inv_wd = s_val;
        if (scat_hit) begin
            inv_we = 1'b1;
        end else if (r_fill_v && !r_def_q) begin
            inv_we = 1'b1;
            inv_wa = r_fill_a;
            inv_wd = r_cur;
        end
        def_we = i_cmd.clr_en || scat_hit;
        def_wa = i_cmd.clr_en ? r_walk[IW-1:0] : s_idx;
        def_wd = !i_cmd.clr_en;
    end

    always_ff @(posedge i_clk) begin
        if (acc_load && store) begin
            r_tab_mem[base_count[TW-1:0]] <= i_frame;
        end
        r_tab_q <= r_tab_mem[tab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (inv_we) begin
            r_inv_mem[inv_wa] <= inv_wd;
        end
        r_inv_q <= r_inv_mem[inv_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (def_we) begin
            r_def_mem[def_wa] <= def_wd;
        end
        r_def_q <= r_def_mem[r_walk[IW-1:0]];
    end

    always_comb begin
        n_pend_frame  = i_frame;
        n_pend_status = STAT_OK;
        n_pend_sel    = SEL_PEND;
        case (i_mode)
            MODE_LOAD: begin
                n_pend_status = store ? STAT_OK : STAT_FULL;
            end
            MODE_FWD: begin
                if (r_count == '0) begin
                    n_pend_frame  = FRAME_BITS'(1);
                    n_pend_status = STAT_EMPTY;
                end else begin
                    n_pend_sel = SEL_TAB;
                end
            end
            MODE_INV: begin
                if (inv_empty) begin
                    n_pend_frame  = r_first;
                    n_pend_status = STAT_EMPTY;
                end else begin
                    n_pend_status = r_wide ? STAT_SPAN : STAT_OK;
                    n_pend_sel    = SEL_INV;
                end
            end
            default: begin
                n_pend_frame = '0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.walk_op)
            WALK_ZERO: n_walk = '0;
            WALK_TOP:  n_walk = WW'(r_count) - WW'(1);
            WALK_INC:  n_walk = r_walk + WW'(1);
            WALK_DEC:  n_walk = r_walk - WW'(1);
            default:   n_walk = r_walk;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_low        <= '0;
            r_high       <= '0;
            r_open       <= 1'b0;
            r_wide       <= 1'b0;
            r_first      <= FRAME_BITS'(1);
            r_pend_build <= 1'b0;
            r_scat_v     <= 1'b0;
            r_fill_v     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_first <= i_cfg_data;
            end
            if (acc_load) begin
                r_open <= !i_last;
                if (store) begin
                    r_count <= base_count + CW'(1);
                    r_low   <= (i_frame < base_low) ? i_frame : base_low;
                    r_high  <= (i_frame > base_high) ? i_frame : base_high;
                end else begin
                    r_count <= base_count;
                    r_low   <= base_low;
                    r_high  <= base_high;
                end
            end
            if (i_cmd.accept) begin
                r_pend_build <= acc_load && i_last;
            end
            if (i_cmd.exec && r_pend_build) begin
                r_wide <= span_wide;
            end
            r_scat_v <= i_cmd.scat_rd;
            r_fill_v <= i_cmd.fill_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_frame  <= n_pend_frame;
            r_pend_status <= n_pend_status;
            r_pend_sel    <= n_pend_sel;
        end
        if (i_cmd.exec && r_pend_build) begin
            r_span   <= span_val;
            r_bfirst <= r_first;
        end
        r_walk   <= n_walk;
        r_scat_i <= r_walk[TW-1:0];
        r_fill_a <= r_walk[IW-1:0];
        if (i_cmd.fill_init) begin
            r_cur <= r_bfirst;
        end else if (r_fill_v) begin
            r_cur <= cur_next;
        end
    end

    always_comb begin
        o_sts.item_imm      = ((i_mode == MODE_LOAD) && !i_last)
                           || ((i_mode != MODE_LOAD) && (i_mode != MODE_FWD)
                               && (i_mode != MODE_INV));
        o_sts.pend_build    = r_pend_build;
        o_sts.walk_span_end = (r_walk == (WW'(r_span) - WW'(1)));
        o_sts.walk_zero     = (r_walk == '0);
    end

    always_comb begin
        o_push = i_cmd.exec || (i_cmd.accept && o_sts.item_imm);
        if (i_cmd.exec) begin
            case (r_pend_sel)
                SEL_TAB: o_mapped = r_tab_q;
                SEL_INV: o_mapped = r_inv_q;
                default: o_mapped = r_pend_frame;
            endcase
            if (r_pend_build && (r_pend_status == STAT_OK) && span_wide) begin
                o_status = STAT_SPAN;
            end else begin
                o_status = r_pend_status;
            end
        end else begin
            o_mapped = (i_mode == MODE_LOAD) ? i_frame : '0;
            o_status = ((i_mode == MODE_LOAD) && !store) ? STAT_FULL : STAT_OK;
        end
    end

endmodule

`default_nettype wire

// ===== sv/efrt_ctrl.sv =====
// Controller: item acceptance and the clear / scatter / fill walk of the
// inverse build. Depends on efrt_pkg.
`default_nettype none

module efrt_ctrl
    import efrt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_q_full,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_CLEAR    = 3'd2;
    localparam logic [2:0] S_SCAT     = 3'd3;
    localparam logic [2:0] S_SCAT_END = 3'd4;
    localparam logic [2:0] S_FILL     = 3'd5;
    localparam logic [2:0] S_FILL_END = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = !i_q_full;
                o_cmd.accept = i_in_valid && !i_q_full;
                if (o_cmd.accept && !i_sts.item_imm) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.pend_build) begin
                    o_cmd.walk_op = WALK_ZERO;
                    n_state       = S_CLEAR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.walk_span_end) begin
                    o_cmd.walk_op = WALK_TOP;
                    n_state       = S_SCAT;
                end else begin
                    o_cmd.walk_op = WALK_INC;
                end
            end
            S_SCAT: begin
                o_cmd.scat_rd = 1'b1;
                if (i_sts.walk_zero) begin
                    n_state = S_SCAT_END;
                end else begin
                    o_cmd.walk_op = WALK_DEC;
                end
            end
            S_SCAT_END: begin
                o_cmd.walk_op   = WALK_ZERO;
                o_cmd.fill_init = 1'b1;
                n_state         = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill_rd = 1'b1;
                if (i_sts.walk_span_end) begin
                    n_state = S_FILL_END;
                end else begin
                    o_cmd.walk_op = WALK_INC;
                end
            end
            S_FILL_END: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== sv/efrt_chk.sv =====
// Port-level checker for explicit_frame_remap_table and its bind.
// Depends on efrt_pkg and the top level.
`default_nettype none

module efrt_chk
    import efrt_pkg::*;
#(
    parameter int FRAME_BITS = EFRT_FRAME_BITS
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire t_mode                        i_in_mode,
    input wire logic                         i_in_last,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic signed [FRAME_BITS-1:0] i_out_mapped_frame,
    input wire t_status                      i_out_status
);

    logic in_beat;

    assign in_beat = i_rst_n && i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_mapped_frame) && $stable(i_out_status)))
        else $error("result beat changed while stalled");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && ((i_in_mode == MODE_FWD) || (i_in_mode == MODE_INV))) |=> !i_in_ready)
        else $error("item taken during query read");

    a_build_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_in_mode == MODE_LOAD) && i_in_last) |=> !i_in_ready ##1 !i_in_ready)
        else $error("item taken during inverse build");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_in_mode == MODE_LOAD) && !i_in_last) |=> i_out_valid)
        else $error("load beat gave no result");

endmodule

bind explicit_frame_remap_table efrt_chk #(
    .FRAME_BITS (FRAME_BITS)
) u_efrt_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_mode          (i_in.mode),
    .i_in_last          (i_in.last),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_mapped_frame (o_out.mapped_frame),
    .i_out_status       (o_out.status)
);

`default_nettype wire

// ===== verif/efrt_remap_checker.sv =====
`timescale 1ns / 100ps
// Checker for explicit_frame_remap_table: watches the item, result and config channels,
// predicts each result from its own copy of the tables, compares them in order.
// Depends on efrt_pkg and efrt_intf.

module efrt_remap_checker
    import efrt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    efrt_in_if        i_item,
    efrt_out_if       i_result,
    efrt_cfg_if       i_cfg,
    output int        o_pending,
    output int        o_fail_count
);

    localparam int TAB_N = EFRT_TABLE_DEPTH;
    localparam int INV_N = EFRT_INVERSE_DEPTH;

    typedef logic signed [EFRT_FRAME_BITS-1:0] t_frame;

    typedef struct {
        t_frame  mapped;
        t_status status;
    } t_remap_result;

    t_frame        loaded_frames [TAB_N];
    t_frame        inverse_map   [INV_N];
    bit            inverse_set   [INV_N];
    int            n_loaded;
    longint        lo_frame;
    longint        hi_frame;
    bit            run_active;
    bit            too_wide;
    t_frame        first_frame;
    t_remap_result expected_results [$];

    function automatic longint clipped_span();
        longint span;
        span = hi_frame - lo_frame + 1;
        return (span > INV_N) ? INV_N : span;
    endfunction

    function automatic void rebuild_inverse();
        longint span;
        longint slot;
        t_frame carry;
        too_wide = (hi_frame - lo_frame + 1) > INV_N;
        span     = clipped_span();
        for (int i = 0; i < INV_N; i++) inverse_set[i] = 1'b0;
        for (int i = 0; i < n_loaded; i++) begin
            slot = longint'(loaded_frames[i]) - lo_frame;
            if (slot >= 0 && slot < span && !inverse_set[slot]) begin
                inverse_map[slot] = longint'(first_frame) + i;
                inverse_set[slot] = 1'b1;
            end
        end
        // fill gaps forward with the last defined output frame
        carry = first_frame;
        for (int i = 0; i < span; i++) begin
            if (inverse_set[i]) carry = inverse_map[i];
            else inverse_map[i] = carry;
        end
    endfunction

    function automatic t_remap_result predict_remap(input t_mode m, input t_frame f,
                                                    input logic l);
        t_remap_result r;
        longint        idx;
        r.mapped = '0;
        r.status = STAT_OK;
        case (m)
            MODE_LOAD: begin
                r.mapped = f;
                if (!run_active) begin
                    n_loaded   = 0;
                    lo_frame   = f;
                    hi_frame   = f;
                    too_wide   = 1'b0;
                    run_active = 1'b1;
                end
                if (n_loaded < TAB_N) begin
                    loaded_frames[n_loaded] = f;
                    n_loaded++;
                    if (f < lo_frame) lo_frame = f;
                    if (f > hi_frame) hi_frame = f;
                end else begin
                    r.status = STAT_FULL;
                end
                if (l) begin
                    run_active = 1'b0;
                    rebuild_inverse();
                    if (r.status == STAT_OK && too_wide) r.status = STAT_SPAN;
                end
            end
            MODE_FWD: begin
                if (n_loaded == 0) begin
                    r.mapped = 1;
                    r.status = STAT_EMPTY;
                end else begin
                    idx = longint'(f) - longint'(first_frame);
                    if (idx < 0) idx = 0;
                    if (idx >= n_loaded) idx = n_loaded - 1;
                    r.mapped = loaded_frames[idx];
                end
            end
            MODE_INV: begin
                if (run_active || n_loaded == 0) begin
                    r.mapped = first_frame;
                    r.status = STAT_EMPTY;
                end else begin
                    idx = longint'(f) - lo_frame;
                    if (idx < 0) idx = 0;
                    if (idx >= clipped_span()) idx = clipped_span() - 1;
                    r.mapped = inverse_map[idx];
                    r.status = too_wide ? STAT_SPAN : STAT_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_remap_result want;
        if (!i_rst_n) begin
            n_loaded     = 0;
            lo_frame     = 0;
            hi_frame     = 0;
            run_active   = 1'b0;
            too_wide     = 1'b0;
            first_frame  = 1;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) first_frame = i_cfg.first_output_frame;
            if (i_item.valid && i_item.ready) begin
                expected_results.insert(expected_results.size(),
                    predict_remap(i_item.mode, i_item.frame, i_item.last));
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, mapped_frame %0d status %0d",
                             $time, i_result.mapped_frame, i_result.status);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.mapped_frame !== want.mapped) begin
                        $display("%0t: mapped_frame expected %0d got %0d",
                                 $time, want.mapped, i_result.mapped_frame);
                        o_fail_count++;
                    end
                    if (i_result.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, i_result.status);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== verif/explicit_frame_remap_table_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for explicit_frame_remap_table: clock, reset, directed and random beats.
// Depends on efrt_pkg, efrt_intf, explicit_frame_remap_table and efrt_remap_checker.

module explicit_frame_remap_table_tb;
    import efrt_pkg::*;

    localparam t_mode  MODE_UNUSED  = 2'd3;
    localparam int     BUILD_WAIT   = 2 * EFRT_INVERSE_DEPTH + EFRT_TABLE_DEPTH + 16;
    localparam int     CYCLE_LIMIT  = 4_000_000;
    localparam int     RANDOM_BEATS = 400;
    localparam longint FRAME_MIN    = -(longint'(1) << (EFRT_FRAME_BITS - 1));
    localparam longint FRAME_MAX    = (longint'(1) << (EFRT_FRAME_BITS - 1)) - 1;

    logic   i_clk;
    logic   i_rst_n;
    int     pending;
    int     fail_count;
    int     cycle_count = 0;
    int     beats_sent;
    bit     calm;
    longint first_frame;
    longint run_base;
    longint run_width;
    int     run_len;

    efrt_in_if  in_ch ();
    efrt_out_if out_ch ();
    efrt_cfg_if cfg_ch ();

    explicit_frame_remap_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    efrt_remap_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (in_ch),
        .i_result     (out_ch),
        .i_cfg        (cfg_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
    end

    function automatic longint random_frame(input int unsigned margin);
        return longint'($urandom_range(0, 32'hFFFFFF - margin)) + FRAME_MIN;
    endfunction

    task automatic send_beat(input t_mode m, input longint f, input logic l);
        int gap;
        gap = 0;
        while (!calm && gap < 6 && $urandom_range(0, 99) < 30) gap++;
        @(negedge i_clk);
        repeat (gap) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= m;
        in_ch.frame <= f[EFRT_FRAME_BITS-1:0];
        in_ch.last  <= l;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (m != MODE_UNUSED) beats_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // a build may still be walking the inverse store after its result beat
    task automatic settle_build();
        drain_results();
        repeat (BUILD_WAIT) @(negedge i_clk);
    endtask

    task automatic write_first_frame(input longint v);
        settle_build();
        cfg_ch.valid              <= 1'b1;
        cfg_ch.first_output_frame <= v[EFRT_FRAME_BITS-1:0];
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        first_frame = v;
    endtask

    task automatic load_run(input longint base, input longint width, input int len,
                            input bit close);
        for (int i = 0; i < len; i++) begin
            send_beat(MODE_LOAD, base + longint'($urandom_range(0, width)),
                      close && (i == len - 1));
        end
        run_base  = base;
        run_width = width;
        run_len   = len;
    endtask

    task automatic query_burst(input int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                send_beat(MODE_FWD, first_frame + longint'($urandom_range(0, run_len + 5)) - 3,
                          $urandom_range(0, 1));
            end else if (sel < 8) begin
                send_beat(MODE_INV, run_base + longint'($urandom_range(0, run_width + 6)) - 3,
                          $urandom_range(0, 1));
            end else begin
                send_beat((sel == 8) ? MODE_FWD : MODE_INV, random_frame(0),
                          $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        int     seq;
        int     start;
        int     next_cfg;
        longint base;
        longint width;
        int     len;
        in_ch.valid               = 1'b0;
        in_ch.mode                = MODE_LOAD;
        in_ch.frame               = '0;
        in_ch.last                = 1'b0;
        out_ch.ready              = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.first_output_frame = '0;
        calm        = 1'b0;
        first_frame = 1;
        run_base    = 0;
        run_width   = 0;
        run_len     = 1;
        beats_sent  = 0;
        i_rst_n     = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, unused mode, open run, full-range span
        send_beat(MODE_FWD, 0, 1'b0);
        send_beat(MODE_INV, FRAME_MAX, 1'b0);
        send_beat(MODE_UNUSED, -1, 1'b1);
        send_beat(MODE_LOAD, FRAME_MAX, 1'b0);
        send_beat(MODE_INV, 0, 1'b0);
        send_beat(MODE_FWD, FRAME_MIN, 1'b0);
        send_beat(MODE_LOAD, FRAME_MIN, 1'b1);
        send_beat(MODE_INV, FRAME_MIN, 1'b0);
        send_beat(MODE_INV, FRAME_MAX, 1'b1);
        send_beat(MODE_FWD, FRAME_MAX, 1'b0);
        // repeated inputs and holes in the inverse
        send_beat(MODE_LOAD, 5, 1'b0);
        send_beat(MODE_LOAD, 3, 1'b0);
        send_beat(MODE_LOAD, 5, 1'b0);
        send_beat(MODE_LOAD, 7, 1'b0);
        send_beat(MODE_LOAD, 3, 1'b1);
        send_beat(MODE_INV, 2, 1'b0);
        send_beat(MODE_INV, 4, 1'b0);
        send_beat(MODE_INV, 6, 1'b0);
        send_beat(MODE_INV, 8, 1'b0);
        // span exactly fills the inverse store, then one past it
        send_beat(MODE_LOAD, 0, 1'b0);
        send_beat(MODE_LOAD, EFRT_INVERSE_DEPTH - 1, 1'b1);
        send_beat(MODE_INV, EFRT_INVERSE_DEPTH - 1, 1'b0);
        send_beat(MODE_LOAD, 0, 1'b0);
        send_beat(MODE_LOAD, EFRT_INVERSE_DEPTH, 1'b1);
        send_beat(MODE_INV, 5000, 1'b0);

        write_first_frame(FRAME_MIN);
        load_run(random_frame(64), 20, 8, 1'b1);
        send_beat(MODE_FWD, FRAME_MAX, 1'b0);
        query_burst(6);

        // output frame numbers wrap
        write_first_frame(FRAME_MAX);
        load_run(random_frame(64), 12, 10, 1'b1);
        query_burst(8);

        // full table with dropped entries and a wide span
        write_first_frame(0);
        base = longint'($urandom_range(0, 1000)) - 3000;
        for (int i = 0; i < EFRT_TABLE_DEPTH + 3; i++) begin
            send_beat(MODE_LOAD, (i == 600) ? base + 5000 : base + longint'($urandom_range(0, 40)),
                      i == EFRT_TABLE_DEPTH + 2);
        end
        run_base  = base;
        run_width = 5000;
        run_len   = EFRT_TABLE_DEPTH;
        send_beat(MODE_FWD, EFRT_TABLE_DEPTH - 1, 1'b0);
        send_beat(MODE_FWD, EFRT_TABLE_DEPTH, 1'b0);
        send_beat(MODE_FWD, -1, 1'b0);
        query_burst(10);

        start    = beats_sent;
        next_cfg = 80;
        while (beats_sent - start < RANDOM_BEATS) begin
            calm = (beats_sent - start >= 150) && (beats_sent - start < 260);
            if (beats_sent - start >= next_cfg) begin
                next_cfg += 80;
                if ($urandom_range(0, 3) == 0) write_first_frame(longint'($urandom_range(0, 8)) - 4);
                else write_first_frame(random_frame(0));
            end
            seq = $urandom_range(0, 99);
            if (seq < 60) begin
                width = ($urandom_range(0, 99) < 3) ? 4100 + $urandom_range(0, 200)
                                                    : $urandom_range(0, 30);
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                load_run(random_frame(5000), width, len, 1'b1);
                query_burst($urandom_range(2, 8));
            end else if (seq < 72) begin
                // run left open, queries in between
                base = random_frame(5000);
                load_run(base, $urandom_range(0, 30), $urandom_range(1, 5), 1'b0);
                query_burst($urandom_range(1, 4));
            end else if (seq < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    send_beat(t_mode'($urandom_range(1, 3)), random_frame(0), $urandom_range(0, 1));
                end
            end else if (seq < 95) begin
                query_burst($urandom_range(1, 6));
            end else begin
                drain_results();
            end
        end
        calm = 1'b0;

        settle_build();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
